FILE: src/s512t_pkg.sv
`timescale 1ns / 1ps
package s512t_pkg;

  localparam int unsigned WordW = 64;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_EMIT
  } state_e;

  // Word source for a schedule-window write.
  typedef enum logic [2:0] {
    SRC_MSG,
    SRC_ZERO,
    SRC_MARK,
    SRC_LEN_HI,
    SRC_LEN_LO
  } wsrc_e;

  // Controller to datapath.
  typedef struct packed {
    logic  push;       // write one word into the window
    wsrc_e src;
    logic  load_final; // select masked final word for the push
    logic  start;      // copy chaining value into working registers
    logic  round;      // run one round
    logic  finish;     // add working registers into chaining value
    logic  reinit;     // return to initial values
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [3:0] fill;
  } dp_stat_t;

  localparam word_t IV [8] = '{
    64'h8C3D37C819544DA2, 64'h73E1996689DCD4D6,
    64'h1DFAB7AE32FF9C82, 64'h679DD514582F9FCF,
    64'h0F6D2B697BD44DA8, 64'h77E36F7304C48942,
    64'h3F9D85A86A1D36C8, 64'h1112E6AD91D692A1
  };

  localparam logic [7:0] PadByte = 8'h80;

  localparam word_t K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage

FILE: src/s512t_if.sv
`timescale 1ns / 1ps
interface s512t_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;
  modport source (output valid, message_word, valid_bytes, final_word, input ready);
  modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface s512t_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_of_digest;
  modport source (output valid, digest_word, word_index, last_of_digest, input ready);
  modport sink (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

FILE: src/sha512_224_hash_engine.sv
`timescale 1ns / 1ps
// Channel   Dir   Payload
// in_req    sink  message_word[63:0], valid_bytes[3:0], final_word
// out_req   src   digest_word[63:0], word_index[1:0], last_of_digest
//
// One request per cycle is taken while the window fills; the 16th word of a
// block holds input off through a load of the working registers, 80 rounds
// on the single round unit, then the chaining add.
// A final request fills each tail block at one word per cycle (up to 16 pad
// words per block) and runs one or two more blocks, then four digest
// requests; input is held off until the last one is taken.
// Reset (rst_ni low, async) loads the SHA-512/224 initial values.
module sha512_224_hash_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  s512t_in_if.sink   in_req,
  s512t_out_if.source out_req
);
  import s512t_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [6:0] round;
  logic [1:0] idx;

  s512t_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_req.valid),
    .in_final_i  (in_req.final_word),
    .in_vb_i     (in_req.valid_bytes),
    .in_ready_o  (in_req.ready),
    .out_valid_o (out_req.valid),
    .out_ready_i (out_req.ready),
    .out_idx_o   (idx),
    .round_o     (round),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  s512t_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .round_i       (round),
    .msg_i         (in_req.message_word),
    .valid_bytes_i (in_req.valid_bytes),
    .final_i       (in_req.final_word),
    .out_idx_i     (idx),
    .stat_o        (stat),
    .digest_o      (out_req.digest_word)
  );

  assign out_req.word_index     = idx;
  assign out_req.last_of_digest = idx == 2'd3;
endmodule

FILE: src/s512t_datapath.sv
`timescale 1ns / 1ps
module s512t_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  s512t_pkg::dp_cmd_t   cmd_i,
  input  logic [6:0]           round_i,
  input  logic [63:0]          msg_i,
  input  logic [3:0]           valid_bytes_i,
  input  logic                 final_i,
  input  logic [1:0]           out_idx_i,
  output s512t_pkg::dp_stat_t  stat_o,
  output logic [63:0]          digest_o
);
  import s512t_pkg::*;

  word_t      cv_q [8];
  word_t      wr_q [8];
  word_t      win_q [16];
  logic [63:0] cnt_q, cnt_d;
  logic [3:0] fill_q;
  word_t      fin_d, push_w;
  logic [3:0] vb;

  // byte count and masked final word
  always_comb begin
    vb = (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
    cnt_d = cnt_q + (final_i ? {60'd0, vb} : 64'd8);
    fin_d = msg_i;
    for (int b = 0; b < 8; b++) begin
      if (b[3:0] == vb) fin_d[63-8*b -: 8] = PadByte;
      else if (b[3:0] > vb) fin_d[63-8*b -: 8] = 8'h00;
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_MSG:    push_w = cmd_i.load_final ? fin_d : msg_i;
      SRC_MARK:   push_w = {PadByte, 56'd0};
      SRC_LEN_HI: push_w = {61'd0, cnt_q[63:61]};
      SRC_LEN_LO: push_w = {cnt_q[60:0], 3'd0};
      default:    push_w = '0;
    endcase
  end

  // round logic
  logic [3:0] ri;
  word_t w_new, w_use, t1, t2, s0, s1, a15, b2, big0, big1, ch, mj;
  always_comb begin
    ri   = round_i[3:0];
    a15  = win_q[ri + 4'd1];
    b2   = win_q[ri + 4'd14];
    s0   = {a15[0], a15[63:1]} ^ {a15[7:0], a15[63:8]} ^ (a15 >> 7);
    s1   = {b2[18:0], b2[63:19]} ^ {b2[60:0], b2[63:61]} ^ (b2 >> 6);
    w_new = win_q[ri] + s0 + win_q[ri + 4'd9] + s1;
    w_use = (round_i < 7'd16) ? win_q[ri] : w_new;
    big1 = {wr_q[4][13:0], wr_q[4][63:14]} ^ {wr_q[4][17:0], wr_q[4][63:18]}
         ^ {wr_q[4][40:0], wr_q[4][63:41]};
    big0 = {wr_q[0][27:0], wr_q[0][63:28]} ^ {wr_q[0][33:0], wr_q[0][63:34]}
         ^ {wr_q[0][38:0], wr_q[0][63:39]};
    ch   = (wr_q[4] & wr_q[5]) ^ (~wr_q[4] & wr_q[6]);
    mj   = (wr_q[0] & wr_q[1]) ^ (wr_q[0] & wr_q[2]) ^ (wr_q[1] & wr_q[2]);
    t1   = wr_q[7] + big1 + ch + K[round_i] + w_use;
    t2   = big0 + mj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) win_q[fill_q] <= push_w;
    else if (cmd_i.round && round_i >= 7'd16) win_q[ri] <= w_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q   <= IV;
      wr_q   <= IV;
      cnt_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.push) begin
        fill_q <= fill_q + 4'd1;
        if (cmd_i.src == SRC_MSG) cnt_q <= cnt_d;
      end
      if (cmd_i.start) wr_q <= cv_q;
      else if (cmd_i.round) begin
        wr_q[7] <= wr_q[6]; wr_q[6] <= wr_q[5]; wr_q[5] <= wr_q[4];
        wr_q[4] <= wr_q[3] + t1;
        wr_q[3] <= wr_q[2]; wr_q[2] <= wr_q[1]; wr_q[1] <= wr_q[0];
        wr_q[0] <= t1 + t2;
      end else if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + wr_q[i];
      end
      if (cmd_i.reinit) begin
        cv_q   <= IV;
        wr_q   <= IV;
        cnt_q  <= '0;
        fill_q <= '0;
      end
    end
  end

  assign stat_o.fill = fill_q;
  assign digest_o = (out_idx_i == 2'd3) ? {32'd0, cv_q[3][63:32]} : cv_q[{1'b0, out_idx_i}];
endmodule

FILE: src/s512t_ctrl.sv
`timescale 1ns / 1ps
module s512t_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_final_i,
  input  logic [3:0]           in_vb_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_idx_o,
  output logic [6:0]           round_o,
  input  s512t_pkg::dp_stat_t  stat_i,
  output s512t_pkg::dp_cmd_t   cmd_o
);
  import s512t_pkg::*;

  state_e state_q, state_d;
  logic [6:0] rnd_q, rnd_d;
  logic [1:0] idx_q, idx_d;
  logic padding_q, padding_d;   // block in flight belongs to the tail
  logic mark_q, mark_d;         // 0x80 still owed as its own word
  logic lenblk_q, lenblk_d;     // block in flight carries the length
  logic lenhi_q;                // last push was the length high word
  logic accept, full;

  assign accept = in_valid_i && in_ready_o;
  assign full   = stat_i.fill == 4'd15;

  always_comb begin
    state_d = state_q; rnd_d = rnd_q; idx_d = idx_q;
    padding_d = padding_q; mark_d = mark_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        if (in_final_i) begin
          padding_d = 1'b1;
          mark_d = in_vb_i >= 4'd8;
        end
        if (full) begin
          state_d = ST_ROUND; rnd_d = '0;
        end else if (in_final_i) state_d = ST_PAD;
      end
      ST_PAD: begin
        if (mark_q) mark_d = 1'b0;
        if (full) begin
          state_d = ST_ROUND; rnd_d = '0;
        end
      end
      ST_ROUND: begin
        if (rnd_q == 7'd81) begin
          if (!padding_q) state_d = ST_IDLE;
          else if (stat_i.fill == 4'd0 && !mark_q) state_d = ST_PAD;
          else state_d = ST_PAD;
        end else rnd_d = rnd_q + 7'd1;
      end
      ST_EMIT: if (out_ready_i) begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = ST_IDLE; padding_d = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // tail complete when the length block just finished
    if (state_q == ST_ROUND && rnd_q == 7'd81 && padding_q && lenblk_q) begin
      state_d = ST_EMIT; idx_d = '0;
    end
  end

  always_comb begin
    lenblk_d = lenblk_q;
    if (state_q == ST_PAD && stat_i.fill == 4'd15 && lenhi_q) lenblk_d = 1'b1;
    if (state_q == ST_EMIT) lenblk_d = 1'b0;
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.src = SRC_ZERO;
    in_ready_o = state_q == ST_IDLE;
    out_valid_o = state_q == ST_EMIT;
    case (state_q)
      ST_IDLE: if (accept) begin
        cmd_o.push = 1'b1; cmd_o.src = SRC_MSG;
        cmd_o.load_final = in_final_i && in_vb_i < 4'd8;
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        if (mark_q) cmd_o.src = SRC_MARK;
        else if (stat_i.fill == 4'd14) cmd_o.src = SRC_LEN_HI;
        else if (stat_i.fill == 4'd15 && lenhi_q) cmd_o.src = SRC_LEN_LO;
        else cmd_o.src = SRC_ZERO;
      end
      ST_ROUND: begin
        if (rnd_q == 7'd0) cmd_o.start = 1'b1;
        else cmd_o.round = 1'b1;
        if (rnd_q == 7'd81) begin
          cmd_o.round = 1'b0; cmd_o.finish = 1'b1;
        end
      end
      ST_EMIT: if (out_ready_i && idx_q == 2'd3) cmd_o.reinit = 1'b1;
      default: ;
    endcase
  end

  // length high word written at slot 14 of a pad pass; low follows in 15
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lenhi_q <= 1'b0;
    else if (cmd_o.push) lenhi_q <= cmd_o.src == SRC_LEN_HI;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; rnd_q <= '0; idx_q <= '0;
      padding_q <= 1'b0; mark_q <= 1'b0; lenblk_q <= 1'b0;
    end else begin
      state_q <= state_d; rnd_q <= rnd_d; idx_q <= idx_d;
      padding_q <= padding_d; mark_q <= mark_d; lenblk_q <= lenblk_d;
    end
  end

  // round index 1..80 drives round 0..79; 0 loads, 81 adds
  assign round_o = (rnd_q == 7'd0 || rnd_q > 7'd80) ? 7'd0 : rnd_q - 7'd1;
  assign out_idx_o = idx_q;

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("emit overlaps input");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && idx_q == 2'd3) |=> state_q == ST_IDLE)
    else $error("no return to idle");
  a_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q <= 7'd81) else $error("round overflow");
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import s512t_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  s512t_in_if  msg_ch ();
  s512t_out_if dig_ch ();

  sha512_224_hash_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (msg_ch.sink),
    .out_req (dig_ch.source)
  );

  // One message request as the driver sends it.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_req_t;

  // One digest request as the engine should send it.
  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } dig_req_t;

  msg_req_t pending_msgs[$];
  dig_req_t expected_digest[$];

  // Predictor state: chaining value, block buffer, length and fill.
  word_t       hash_h[8];
  word_t       block_buf[16];
  logic [63:0] msg_len_bytes;
  logic [3:0]  buf_fill;

  int unsigned n_mismatch = 0;
  int unsigned n_digests  = 0;
  int unsigned n_accepted = 0;
  longint unsigned cycle_cnt = 0;
  bit          idle_free = 1'b0;  // no idling in the last part
  bit          hold_send = 1'b0;  // sender pause once drained
  bit          in_taken  = 1'b0;  // request accepted at the last rising edge

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void hash_reinit();
    for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
    msg_len_bytes = '0;
    buf_fill = '0;
  endfunction

  // 80 rounds over block_buf, with the schedule built in a full array.
  function automatic void compress_buf();
    word_t w[80];
    word_t r[8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 80; i++) begin
      s0 = rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7);
      s1 = rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = hash_h[i];
    for (int i = 0; i < 80; i++) begin
      t1 = r[7] + (rotr(r[4], 14) ^ rotr(r[4], 18) ^ rotr(r[4], 41))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + K[i] + w[i];
      t2 = (rotr(r[0], 28) ^ rotr(r[0], 34) ^ rotr(r[0], 39))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += r[i];
  endfunction

  function automatic void buf_push(word_t w);
    block_buf[buf_fill] = w;
    buf_fill = buf_fill + 4'd1;
    if (buf_fill == 4'd0) compress_buf();
  endfunction

  // Feed one accepted request; a final one queues the four digest words.
  function automatic void predict_digest(msg_req_t m);
    int unsigned nb;
    word_t       w;
    dig_req_t    d;
    if (!m.last) begin
      msg_len_bytes += 64'd8;
      buf_push(m.word);
      return;
    end
    nb = (m.nbytes > 4'd8) ? 8 : m.nbytes;
    msg_len_bytes += 64'(nb);
    w = (nb == 0) ? '0 : (m.word & ({64{1'b1}} << (8 * (8 - nb))));
    if (nb < 8) begin
      buf_push(w | (64'(PadByte) << (8 * (7 - nb))));
    end else begin
      buf_push(w);
      buf_push(64'(PadByte) << 56);
    end
    if (buf_fill > 4'd14) buf_push('0);
    while (buf_fill != 4'd14) buf_push('0);
    buf_push(msg_len_bytes >> 61);
    buf_push(msg_len_bytes << 3);
    for (int k = 0; k < 4; k++) begin
      d.word = (k < 3) ? hash_h[k] : (hash_h[3] >> 32);
      d.idx  = 2'(k);
      d.last = (k == 3);
      expected_digest.push_back(d);
    end
    hash_reinit();
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Queue a message of n full words plus a final word with nb bytes.
  task automatic queue_msg(int unsigned n, logic [3:0] nb);
    msg_req_t m;
    for (int i = 0; i < n; i++) begin
      m.word = rand64();
      m.nbytes = 4'($urandom_range(0, 15));  // ignored on non-final words
      m.last = 1'b0;
      pending_msgs.push_back(m);
    end
    m.word = rand64();
    m.nbytes = nb;
    m.last = 1'b1;
    pending_msgs.push_back(m);
  endtask

  // Input side: accepted requests are taken at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && msg_ch.valid && msg_ch.ready) begin
      predict_digest({msg_ch.message_word, msg_ch.valid_bytes, msg_ch.final_word});
      n_accepted++;
      void'(pending_msgs.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Driver: changes at the falling edge, with random idle bursts.
  int unsigned send_gap = 0;
  initial begin
    msg_ch.valid = 1'b0;
    msg_ch.message_word = '0;
    msg_ch.valid_bytes = '0;
    msg_ch.final_word = 1'b0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (send_gap > 0) send_gap--;
      else if (!idle_free && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
      if (msg_ch.valid && !in_taken) begin
        // request still waiting: hold it
      end else if (pending_msgs.size() > 0 && send_gap == 0 && !hold_send) begin
        msg_ch.valid        <= 1'b1;
        msg_ch.message_word <= pending_msgs[0].word;
        msg_ch.valid_bytes  <= pending_msgs[0].nbytes;
        msg_ch.final_word   <= pending_msgs[0].last;
      end else begin
        msg_ch.valid <= 1'b0;
      end
    end
  end

  // Sink ready: random stalls, changed at the falling edge.
  int unsigned stall_gap = 0;
  initial dig_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_gap > 0) stall_gap--;
      else if (!idle_free && $urandom_range(0, 5) == 0) stall_gap = $urandom_range(1, 6);
      dig_ch.ready <= (stall_gap == 0);
    end
  end

  // Monitor: sample digest requests at the rising edge.
  always @(posedge clk_i) begin
    dig_req_t e;
    if (rst_ni) begin
      cycle_cnt++;
      if (dig_ch.valid && dig_ch.ready) begin
        n_digests++;
        if (expected_digest.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected digest word %h", dig_ch.digest_word);
        end else begin
          e = expected_digest.pop_front();
          if (e.word !== dig_ch.digest_word || e.idx !== dig_ch.word_index ||
              e.last !== dig_ch.last_of_digest) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d", e.word, e.idx,
                       e.last, dig_ch.digest_word, dig_ch.word_index, dig_ch.last_of_digest);
          end
        end
      end
      if (cycle_cnt > 400000) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    hash_reinit();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, every final byte count, exact and near block
    // boundaries, oversized byte counts, all-ones and all-zero words.
    queue_msg(0, 4'd0);
    for (int nb = 1; nb <= 8; nb++) queue_msg(0, 4'(nb));
    queue_msg(0, 4'd15);
    queue_msg(13, 4'd8);  // 0x80 mark lands in a fresh word, length spills
    queue_msg(14, 4'd0);
    queue_msg(15, 4'd8);  // exact 128-byte message
    begin
      msg_req_t m;
      m.word = '1; m.nbytes = 4'd8; m.last = 1'b0;
      pending_msgs.push_back(m);
      m.word = '1; m.nbytes = 4'd9; m.last = 1'b1;
      pending_msgs.push_back(m);
      m.word = '0; m.nbytes = 4'd7; m.last = 1'b1;
      pending_msgs.push_back(m);
    end

    // Once every request is sent and every digest taken, pause the sender.
    wait (pending_msgs.size() == 0 && expected_digest.size() == 0);
    @(negedge clk_i);
    hold_send = 1'b1;
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    hold_send = 1'b0;

    // Random messages, mostly short, a few spanning several blocks.
    while (pending_msgs.size() < 260) begin
      if ($urandom_range(0, 7) == 0) queue_msg($urandom_range(16, 40), 4'($urandom_range(0, 15)));
      else queue_msg($urandom_range(0, 18), 4'($urandom_range(0, 8)));
    end
    wait (pending_msgs.size() < 60);
    @(negedge clk_i);
    idle_free = 1'b1;
    while (pending_msgs.size() < 120) queue_msg($urandom_range(0, 17), 4'($urandom_range(0, 8)));

    wait (pending_msgs.size() == 0 && expected_digest.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d message requests and %0d digest words, ", n_accepted, n_digests);
    $display("including empty, partial, exact-block and oversized byte-count tails");
    if (n_mismatch == 0 && expected_digest.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("tb: failure");
    end
    $finish;
  end
endmodule
